@@ rtl/core/gtr_pkg.sv @@
package gtr_pkg;

  localparam int SCREEN_WIDTH  = 368;
  localparam int SCREEN_HEIGHT = 448;
  localparam int TAP_SLOP      = 15;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;
  localparam int COORD_W    = 11;
  localparam int RAW_W      = 10;
  localparam int TIME_W     = 32;

  typedef enum logic [2:0] {
    G_NONE  = 3'd0,
    G_TAP   = 3'd1,
    G_LEFT  = 3'd2,
    G_RIGHT = 3'd3,
    G_UP    = 3'd4,
    G_DOWN  = 3'd5,
    G_DTAP  = 3'd6
  } gest_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROTATION     = 3'd0,
    REG_IMAGE_MODE   = 3'd1,
    REG_SWIPE_THRESH = 3'd2,
    REG_SWIPE_CROSS  = 3'd3,
    REG_BOTTOM_ZONE  = 3'd4,
    REG_DTAP_WINDOW  = 3'd5,
    REG_DTAP_DIST    = 3'd6,
    REG_DTAP_DEBOUNCE = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]  rotation;
    logic        image_mode;
    logic [9:0]  swipe_threshold;
    logic [9:0]  swipe_max_cross;
    logic [9:0]  bottom_zone;
    logic [20:0] dtap_window_us;
    logic [10:0] dtap_max_dist;
    logic [19:0] dtap_debounce_us;
  } cfg_t;

  typedef struct packed {
    logic                      clr;
    logic                      rel;
    logic [TIME_W-1:0]         now_us;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
  } dtap_req_t;

endpackage

@@ rtl/core/gtr_rotate.sv @@
module gtr_rotate (
  input  logic [1:0]                          rotation,
  input  logic [gtr_pkg::RAW_W-1:0]           raw_x,
  input  logic [gtr_pkg::RAW_W-1:0]           raw_y,
  output logic signed [gtr_pkg::COORD_W-1:0]  pos_x,
  output logic signed [gtr_pkg::COORD_W-1:0]  pos_y
);

  localparam logic signed [11:0] WM1 = 12'(gtr_pkg::SCREEN_WIDTH - 1);
  localparam logic signed [11:0] HM1 = 12'(gtr_pkg::SCREEN_HEIGHT - 1);

  logic signed [11:0] x0, y0, x1, y1, x2, y2;

  always_comb begin
    x0 = $signed({2'b00, raw_x});
    y0 = $signed({2'b00, raw_y});
    if (rotation[1]) begin
      x1 = WM1 - x0;
      y1 = HM1 - y0;
    end else begin
      x1 = x0;
      y1 = y0;
    end
    if (rotation[0]) begin
      x2 = HM1 - y1;
      y2 = x1;
    end else begin
      x2 = x1;
      y2 = y1;
    end
  end

  assign pos_x = x2[gtr_pkg::COORD_W-1:0];
  assign pos_y = y2[gtr_pkg::COORD_W-1:0];

endmodule

@@ rtl/core/gtr_stroke.sv @@
module gtr_stroke (
  input  gtr_pkg::cfg_t                       cfg,
  input  logic signed [gtr_pkg::COORD_W-1:0]  start_x,
  input  logic signed [gtr_pkg::COORD_W-1:0]  start_y,
  input  logic signed [gtr_pkg::COORD_W-1:0]  recent_x,
  input  logic signed [gtr_pkg::COORD_W-1:0]  recent_y,
  output gtr_pkg::gest_code_t                 gesture
);

  localparam logic signed [11:0] SW   = 12'(gtr_pkg::SCREEN_WIDTH);
  localparam logic signed [11:0] SH   = 12'(gtr_pkg::SCREEN_HEIGHT);
  localparam logic [11:0]        SLOP = 12'(gtr_pkg::TAP_SLOP);

  logic signed [11:0] dx, dy, lim, h, sy;
  logic [11:0]        ax, ay, thr, xmax;

  always_comb begin
    dx    = {recent_x[10], recent_x} - {start_x[10], start_x};
    dy    = {recent_y[10], recent_y} - {start_y[10], start_y};
    ax    = dx[11] ? 12'(-dx) : 12'(dx);
    ay    = dy[11] ? 12'(-dy) : 12'(dy);
    thr   = {2'b00, cfg.swipe_threshold};
    xmax  = {2'b00, cfg.swipe_max_cross};
    h     = cfg.rotation[0] ? SW : SH;
    lim   = h - $signed({2'b00, cfg.bottom_zone});
    sy    = {start_y[10], start_y};
    if (ax > thr && ay < xmax) begin
      gesture = (!dx[11] && dx != 12'sd0) ? gtr_pkg::G_LEFT : gtr_pkg::G_RIGHT;
    end else if (ay > thr && ax < xmax) begin
      if (dy[11]) begin
        gesture = (sy >= lim) ? gtr_pkg::G_UP : gtr_pkg::G_NONE;
      end else begin
        gesture = gtr_pkg::G_DOWN;
      end
    end else if (ax < SLOP && ay < SLOP) begin
      gesture = gtr_pkg::G_TAP;
    end else begin
      gesture = gtr_pkg::G_NONE;
    end
  end

endmodule

@@ rtl/core/gtr_dtap.sv @@
module gtr_dtap (
  input  logic                clk,
  input  logic                rst_n,
  input  gtr_pkg::cfg_t       cfg,
  input  gtr_pkg::dtap_req_t  req,
  output logic                hit
);

  logic                                fw_r, fw_nxt;
  logic                                rs_r, rs_nxt;
  logic [gtr_pkg::TIME_W-1:0]          ft_r, ft_nxt;
  logic [gtr_pkg::TIME_W-1:0]          rt_r, rt_nxt;
  logic signed [gtr_pkg::COORD_W-1:0]  fx_r, fx_nxt;
  logic signed [gtr_pkg::COORD_W-1:0]  fy_r, fy_nxt;

  logic [gtr_pkg::TIME_W-1:0] since_rel, since_tap;
  logic signed [11:0]         ddx, ddy;
  logic [12:0]                manh;
  logic                       bounce, win;

  always_comb begin
    since_rel = req.now_us - rt_r;
    since_tap = req.now_us - ft_r;
    ddx       = {req.pos_x[10], req.pos_x} - {fx_r[10], fx_r};
    ddy       = {req.pos_y[10], req.pos_y} - {fy_r[10], fy_r};
    manh      = 13'(ddx[11] ? 12'(-ddx) : 12'(ddx)) + 13'(ddy[11] ? 12'(-ddy) : 12'(ddy));
    bounce    = rs_r && (since_rel < 32'(cfg.dtap_debounce_us));
    win       = fw_r && (since_tap <= 32'(cfg.dtap_window_us))
                && (manh <= 13'(cfg.dtap_max_dist));
    hit       = req.rel && !bounce && win;

    fw_nxt = fw_r;
    rs_nxt = rs_r;
    ft_nxt = ft_r;
    rt_nxt = rt_r;
    fx_nxt = fx_r;
    fy_nxt = fy_r;
    if (req.clr) begin
      fw_nxt = 1'b0;
      rs_nxt = 1'b0;
      rt_nxt = '0;
    end else if (req.rel && !bounce) begin
      rs_nxt = 1'b1;
      rt_nxt = req.now_us;
      if (win) begin
        fw_nxt = 1'b0;
      end else begin
        fw_nxt = 1'b1;
        ft_nxt = req.now_us;
        fx_nxt = req.pos_x;
        fy_nxt = req.pos_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= 1'b0;
      rs_r <= 1'b0;
    end else begin
      fw_r <= fw_nxt;
      rs_r <= rs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ft_r <= ft_nxt;
    rt_r <= rt_nxt;
    fx_r <= fx_nxt;
    fy_r <= fy_nxt;
  end

endmodule

@@ rtl/core/touch_gesture_recognizer.sv @@
// Touch gesture recognizer: one touch sample per transfer in, exactly one
// result per sample out, in order, at up to one sample per clock. A sample
// is held in an input register, rotated and classified combinationally, and
// the result lands in an output register; the input stalls only while the
// output register holds an untaken result. Gesture codes: 0 none, 1 tap,
// 2 swipe left, 3 swipe right, 4 swipe up, 5 swipe down, 6 double tap;
// out_is_pressed is the pointer state after the sample. Configuration
// writes apply immediately and must be made while no sample is in flight;
// writing image_mode clears double tap history.
module touch_gesture_recognizer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_touched,
  input  logic [gtr_pkg::RAW_W-1:0]           in_touch_x,
  input  logic [gtr_pkg::RAW_W-1:0]           in_touch_y,
  input  logic [gtr_pkg::TIME_W-1:0]          in_now_us,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2:0]                          out_gesture,
  output logic                                out_is_pressed,
  input  logic                                cfg_wr_en,
  input  logic [gtr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gtr_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);

  gtr_pkg::cfg_t cfg_r;

  logic                               s1_v_r;
  logic                               s1_touched_r;
  logic [gtr_pkg::RAW_W-1:0]          s1_x_r, s1_y_r;
  logic [gtr_pkg::TIME_W-1:0]         s1_now_r;

  logic                               press_r, press_nxt;
  logic signed [gtr_pkg::COORD_W-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [gtr_pkg::COORD_W-1:0] rx_r, rx_nxt, ry_r, ry_nxt;

  logic                               ov_r;
  gtr_pkg::gest_code_t                og_r, og_nxt;
  logic                               op_r;

  logic                               adv;
  logic signed [gtr_pkg::COORD_W-1:0] px, py;
  gtr_pkg::gest_code_t                stroke_g;
  gtr_pkg::dtap_req_t                 dreq;
  logic                               dhit;

  assign adv      = s1_v_r && (!ov_r || out_ready);
  assign in_ready = !s1_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rotation         <= 2'd0;
      cfg_r.image_mode       <= 1'b0;
      cfg_r.swipe_threshold  <= 10'd60;
      cfg_r.swipe_max_cross  <= 10'd80;
      cfg_r.bottom_zone      <= 10'd60;
      cfg_r.dtap_window_us   <= 21'd300000;
      cfg_r.dtap_max_dist    <= 11'd40;
      cfg_r.dtap_debounce_us <= 20'd50000;
    end else if (cfg_wr_en) begin
      case (gtr_pkg::cfg_idx_t'(cfg_index))
        gtr_pkg::REG_ROTATION:      cfg_r.rotation         <= cfg_wr_data[1:0];
        gtr_pkg::REG_IMAGE_MODE:    cfg_r.image_mode       <= cfg_wr_data[0];
        gtr_pkg::REG_SWIPE_THRESH:  cfg_r.swipe_threshold  <= cfg_wr_data[9:0];
        gtr_pkg::REG_SWIPE_CROSS:   cfg_r.swipe_max_cross  <= cfg_wr_data[9:0];
        gtr_pkg::REG_BOTTOM_ZONE:   cfg_r.bottom_zone      <= cfg_wr_data[9:0];
        gtr_pkg::REG_DTAP_WINDOW:   cfg_r.dtap_window_us   <= cfg_wr_data[20:0];
        gtr_pkg::REG_DTAP_DIST:     cfg_r.dtap_max_dist    <= cfg_wr_data[10:0];
        gtr_pkg::REG_DTAP_DEBOUNCE: cfg_r.dtap_debounce_us <= cfg_wr_data[19:0];
        default: ;
      endcase
    end
  end

  gtr_rotate u_rotate (
    .rotation (cfg_r.rotation),
    .raw_x    (s1_x_r),
    .raw_y    (s1_y_r),
    .pos_x    (px),
    .pos_y    (py)
  );

  gtr_stroke u_stroke (
    .cfg      (cfg_r),
    .start_x  (sx_r),
    .start_y  (sy_r),
    .recent_x (rx_r),
    .recent_y (ry_r),
    .gesture  (stroke_g)
  );

  always_comb begin
    dreq.clr    = cfg_wr_en && (gtr_pkg::cfg_idx_t'(cfg_index) == gtr_pkg::REG_IMAGE_MODE);
    dreq.rel    = adv && !s1_touched_r && press_r && cfg_r.image_mode;
    dreq.now_us = s1_now_r;
    dreq.pos_x  = rx_r;
    dreq.pos_y  = ry_r;
  end

  gtr_dtap u_dtap (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .req   (dreq),
    .hit   (dhit)
  );

  always_comb begin
    press_nxt = press_r;
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    rx_nxt    = rx_r;
    ry_nxt    = ry_r;
    og_nxt    = gtr_pkg::G_NONE;
    if (s1_touched_r) begin
      if (!press_r) begin
        sx_nxt = px;
        sy_nxt = py;
      end
      press_nxt = 1'b1;
      rx_nxt    = px;
      ry_nxt    = py;
    end else if (press_r) begin
      press_nxt = 1'b0;
      if (cfg_r.image_mode) begin
        og_nxt = dhit ? gtr_pkg::G_DTAP : gtr_pkg::G_NONE;
      end else begin
        og_nxt = stroke_g;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      ov_r    <= 1'b0;
      press_r <= 1'b0;
      sx_r    <= '0;
      sy_r    <= '0;
      rx_r    <= '0;
      ry_r    <= '0;
    end else begin
      if (in_ready) begin
        s1_v_r <= in_valid;
      end
      ov_r <= adv || (ov_r && !out_ready);
      if (adv) begin
        press_r <= press_nxt;
        sx_r    <= sx_nxt;
        sy_r    <= sy_nxt;
        rx_r    <= rx_nxt;
        ry_r    <= ry_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_touched_r <= in_touched;
      s1_x_r       <= in_touch_x;
      s1_y_r       <= in_touch_y;
      s1_now_r     <= in_now_us;
    end
    if (adv) begin
      og_r <= og_nxt;
      op_r <= press_nxt;
    end
  end

  assign out_valid      = ov_r;
  assign out_gesture    = og_r;
  assign out_is_pressed = op_r;

endmodule

@@ rtl/core/gtr_checker.sv @@
module gtr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_gesture,
  input logic       out_is_pressed
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_gesture) && $stable(out_is_pressed))
    else $error("result changed while stalled");

  a_pressed_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_pressed |-> out_gesture == gtr_pkg::G_NONE)
    else $error("gesture reported while pressed");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not empty after reset");

endmodule

bind touch_gesture_recognizer gtr_checker u_gtr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_gesture    (out_gesture),
  .out_is_pressed (out_is_pressed)
);
